// ===== rtl/core/np_pkg.sv =====
// Package for the next-permutation block: data width and the sequencer state type.
// No dependencies; imported by np_cmp and next_permutation.
package np_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PREP,
        ST_SCAN,
        ST_SUCC,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_REV_RA,
        ST_REV_RB,
        ST_REV_WA,
        ST_REV_WB,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_np_state;

endpackage

// ===== rtl/core/np_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the element store of the next-permutation block.
module np_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/np_cmp.sv =====
// Shared two's complement signed comparator of the next-permutation sequencer.
// Depends on np_pkg for the data width.
module np_cmp
    import np_pkg::*;
(
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output logic              o_less
);

    // Two's complement ordering: true when a is strictly below b.
    assign o_less = $signed(i_a) < $signed(i_b);

endmodule

// ===== rtl/core/next_permutation.sv =====
// Next lexicographic permutation of a streamed sequence of signed 32-bit elements.
// Depends on np_pkg, np_ram (element store) and np_cmp (shared comparator).
//
// Elements arrive one per transaction on the slave side, at most one per cycle, until a
// transaction with tlast set; up to MAX_LEN are stored and any further ones are
// dropped, which sets the overflow flag in tuser of every result. The block then
// stops accepting input while a sequencer works on the store through its single
// read port and one shared comparator: a scan for the rightmost ascent, a scan for
// the rightmost larger element, a swap of the two and a reversal of the tail.
// A sequence without an ascent is reversed whole and flagged as wrapped in tuser.
// Results then leave one at a time, each needing a store read and held while tready
// is low, with tlast on the final element; the input side opens again while the last
// result still waits in the output register.
module next_permutation
    import np_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] element_value
    input  logic        s_axis_tlast,   // is_final
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] out_value
    output logic        m_axis_tlast,   // out_final
    output logic [1:0]  m_axis_tuser    // [0] wrapped, [1] overflowed
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    t_np_state r_state, n_state;

    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_ovf, n_ovf;
    logic              r_wrap, n_wrap;
    logic [AW-1:0]     r_last, n_last;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic              r_go, n_go;
    logic              r_rv, n_rv;
    logic [AW-1:0]     r_qa, n_qa;
    logic              r_first, n_first;
    logic [AW-1:0]     r_pivot, n_pivot;
    logic [AW-1:0]     r_succ, n_succ;
    logic [AW-1:0]     r_lo, n_lo;
    logic [AW-1:0]     r_hi, n_hi;
    logic              r_ov, n_ov;

    logic [DATA_W-1:0] r_tmp, n_tmp;
    logic [DATA_W-1:0] r_pval, n_pval;
    logic [DATA_W-1:0] r_sval, n_sval;
    logic [DATA_W-1:0] r_odata, n_odata;
    logic              r_olast, n_olast;
    logic              r_owrap, n_owrap;
    logic              r_oovf, n_oovf;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic [DATA_W-1:0] cmp_a;
    logic [DATA_W-1:0] cmp_b;
    logic              cmp_less;
    logic [AW-1:0]     last_c;

    np_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The successor scan compares the pivot against each element; the ascent
    // scan compares each element against its right-hand neighbour.
    assign cmp_a = (r_state == ST_SUCC) ? r_pval : mem_rdata;
    assign cmp_b = (r_state == ST_SUCC) ? mem_rdata : r_tmp;

    np_cmp u_cmp (
        .i_a    (cmp_a),
        .i_b    (cmp_b),
        .o_less (cmp_less)
    );

    assign last_c = AW'(r_cnt - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_go    <= 1'b0;
            r_rv    <= 1'b0;
            r_first <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_go    <= n_go;
            r_rv    <= n_rv;
            r_first <= n_first;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wrap  <= n_wrap;
        r_last  <= n_last;
        r_ptr   <= n_ptr;
        r_qa    <= n_qa;
        r_pivot <= n_pivot;
        r_succ  <= n_succ;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_tmp   <= n_tmp;
        r_pval  <= n_pval;
        r_sval  <= n_sval;
        r_odata <= n_odata;
        r_olast <= n_olast;
        r_owrap <= n_owrap;
        r_oovf  <= n_oovf;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        n_wrap    = r_wrap;
        n_last    = r_last;
        n_ptr     = r_ptr;
        n_go      = r_go;
        n_qa      = r_qa;
        n_first   = r_first;
        n_pivot   = r_pivot;
        n_succ    = r_succ;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_tmp     = r_tmp;
        n_pval    = r_pval;
        n_sval    = r_sval;
        n_odata   = r_odata;
        n_olast   = r_olast;
        n_owrap   = r_owrap;
        n_oovf    = r_oovf;
        n_ov      = r_ov && !m_axis_tready;
        mem_we    = 1'b0;
        mem_waddr = r_cnt[AW-1:0];
        mem_wdata = s_axis_tdata;
        mem_re    = 1'b0;
        mem_raddr = r_ptr;
        s_axis_tready = 1'b0;

        unique case (r_state)
            ST_LOAD: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (r_cnt < CW'(MAX_LEN)) begin
                        mem_we = 1'b1;
                        n_cnt  = r_cnt + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_state = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                n_last  = last_c;
                n_wrap  = 1'b0;
                n_first = 1'b1;
                n_go    = 1'b1;
                if (r_cnt <= CW'(1)) begin
                    n_ptr   = '0;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_ptr   = last_c;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                mem_re = r_go;
                if (r_go) begin
                    n_ptr = r_ptr - 1'b1;
                    n_go  = (r_ptr != '0);
                end
                if (r_rv) begin
                    if (r_first) begin
                        n_tmp   = mem_rdata;
                        n_first = 1'b0;
                    end else if (cmp_less) begin
                        // Rightmost ascent found: look for its successor next.
                        n_pivot = r_qa;
                        n_pval  = mem_rdata;
                        n_ptr   = r_last;
                        n_go    = 1'b1;
                        mem_re  = 1'b0;
                        n_state = ST_SUCC;
                    end else begin
                        n_tmp = mem_rdata;
                        if (r_qa == '0) begin
                            n_wrap  = 1'b1;
                            n_lo    = '0;
                            n_hi    = r_last;
                            mem_re  = 1'b0;
                            n_state = ST_REV_RA;
                        end
                    end
                end
            end
            ST_SUCC: begin
                mem_re = r_go;
                if (r_go) begin
                    n_ptr = r_ptr - 1'b1;
                    n_go  = ((r_ptr - 1'b1) != r_pivot);
                end
                if (r_rv && cmp_less) begin
                    n_succ  = r_qa;
                    n_sval  = mem_rdata;
                    mem_re  = 1'b0;
                    n_state = ST_SWAP_A;
                end
            end
            ST_SWAP_A: begin
                mem_we    = 1'b1;
                mem_waddr = r_pivot;
                mem_wdata = r_sval;
                n_state   = ST_SWAP_B;
            end
            ST_SWAP_B: begin
                mem_we    = 1'b1;
                mem_waddr = r_succ;
                mem_wdata = r_pval;
                n_lo      = r_pivot + 1'b1;
                n_hi      = r_last;
                n_state   = ST_REV_RA;
            end
            ST_REV_RA: begin
                if (r_lo >= r_hi) begin
                    n_ptr   = '0;
                    n_state = ST_EMIT_RD;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_lo;
                    n_state   = ST_REV_RB;
                end
            end
            ST_REV_RB: begin
                mem_re    = 1'b1;
                mem_raddr = r_hi;
                n_tmp     = mem_rdata;
                n_state   = ST_REV_WA;
            end
            ST_REV_WA: begin
                mem_we    = 1'b1;
                mem_waddr = r_lo;
                mem_wdata = mem_rdata;
                n_state   = ST_REV_WB;
            end
            ST_REV_WB: begin
                mem_we    = 1'b1;
                mem_waddr = r_hi;
                mem_wdata = r_tmp;
                n_lo      = r_lo + 1'b1;
                n_hi      = r_hi - 1'b1;
                n_state   = ST_REV_RA;
            end
            ST_EMIT_RD: begin
                // Only fetch when the output register is free by the next cycle.
                if (!r_ov || m_axis_tready) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr;
                    n_state   = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                n_ov    = 1'b1;
                n_odata = mem_rdata;
                n_olast = (r_ptr == r_last);
                n_owrap = r_wrap;
                n_oovf  = r_ovf;
                if (r_ptr == r_last) begin
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_state = ST_LOAD;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        n_rv = mem_re;
        if (mem_re) begin
            n_qa = mem_raddr;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = {r_oovf, r_owrap};

endmodule
